// File: design/smm_pkg.sv
// Shared types, constants and float helpers for the sparse matrix multiply block.
`timescale 1ns / 1ps
package smm_pkg;

   localparam int MAX_COLUMNS_DEF    = 64;
   localparam int MAX_B_ROWS_DEF     = 64;
   localparam int MAX_B_NONZEROS_DEF = 1024;

   localparam int OP_W    = 3;
   localparam int ADDR_W  = 10;
   localparam int PTR_W   = 11;
   localparam int COL_W   = 6;
   localparam int VAL_W   = 32;
   localparam int ROW_W   = 16;
   localparam int TOTAL_W = 23;
   localparam int CSR_W   = 7;

   localparam logic [OP_W-1:0] OP_LOAD_PTR = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_NZ  = 3'd1;
   localparam logic [OP_W-1:0] OP_A_NZ     = 3'd2;
   localparam logic [OP_W-1:0] OP_ROW_END  = 3'd3;
   localparam logic [OP_W-1:0] OP_NEW      = 3'd4;

   localparam logic [CSR_W-1:0]   COLUMN_COUNT_RESET = 7'd64;
   localparam logic [ROW_W-1:0]   ROW_SAT            = 16'hFFFF;
   localparam logic [TOTAL_W:0]   TOTAL_SAT          = 24'h7FFFFF;
   localparam logic [VAL_W-1:0]   FP_DEFAULT_NAN     = 32'hFFC00000;
   localparam logic [VAL_W-1:0]   FP_QUIET_BIT       = 32'h00400000;

   // Cycles between the operand read and the registered multiply-add result.
   localparam logic [2:0] FP_WAIT = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RP_START,
      ST_RP_END,
      ST_SET_END,
      ST_WALK,
      ST_BCHK,
      ST_CALC,
      ST_WRITE,
      ST_ROW_BEGIN,
      ST_SCAN,
      ST_EMIT,
      ST_EMPTY,
      ST_ROW_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic cap;
      logic wr_rp;
      logic wr_b;
      logic new_prod;
      logic rd_rp;
      logic rp_sel;
      logic set_p;
      logic set_end;
      logic rd_b;
      logic inc_p;
      logic rd_sum;
      logic wr_sum;
      logic commit_total;
      logic scan_rst;
      logic inc_k;
      logic rd_scan;
      logic emit;
      logic emit_empty;
      logic clear_row;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            row_ok;
      logic            p_done;
      logic            col_ok;
      logic            occ_k;
      logic            occ_none;
      logic            is_last;
   } status_type;

   function automatic logic [5:0] fp_lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            n = 6'(47 - i);
         end
      end
      return n;
   endfunction

   // Rounds a normalised significand (leading one at bit 47) to nearest even.
   function automatic logic [31:0] fp_round_pack(input logic sign,
                                                 input logic signed [11:0] exp,
                                                 input logic [47:0] sig);
      logic [95:0] shifted;
      logic [47:0] work;
      logic [6:0]  amt;
      logic [7:0]  e8;
      logic        lost;
      logic        g;
      logic        st;
      logic [30:0] base;
      logic [30:0] rounded;
      shifted = '0;
      work    = sig;
      amt     = 7'd0;
      e8      = 8'd0;
      lost    = 1'b0;
      if (exp >= 12'sd255) begin
         return {sign, 8'hFF, 23'd0};
      end
      if (exp >= 12'sd1) begin
         e8 = exp[7:0];
      end else begin
         if (exp < -12'sd61) begin
            amt = 7'd63;
         end else begin
            amt = 7'(12'sd1 - exp);
         end
         shifted = {sig, 48'd0} >> amt;
         work    = shifted[95:48];
         lost    = |shifted[47:0];
      end
      g       = work[23];
      st      = (|work[22:0]) | lost;
      base    = {e8, work[46:24]};
      rounded = base + 31'(g & (st | work[24]));
      return {sign, rounded};
   endfunction

endpackage

// File: design/smm_ctrl.sv
// Controller state machine for the sparse matrix multiply block.
`timescale 1ns / 1ps
module smm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  smm_pkg::status_type status,
   output smm_pkg::cmd_type    cmd
);

   smm_pkg::ctrl_state_type state_ff, state_in;
   logic [2:0] wait_ff, wait_in;
   logic       accept;

   assign accept = start && (state_ff == smm_pkg::ST_IDLE);
   assign busy   = (state_ff != smm_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smm_pkg::ST_IDLE;
         wait_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      case (state_ff)
         smm_pkg::ST_IDLE: begin
            if (accept) begin
               if (status.op == smm_pkg::OP_A_NZ && status.row_ok) begin
                  state_in = smm_pkg::ST_RP_START;
               end else if (status.op == smm_pkg::OP_ROW_END) begin
                  state_in = smm_pkg::ST_ROW_BEGIN;
               end
            end
         end
         smm_pkg::ST_RP_START: state_in = smm_pkg::ST_RP_END;
         smm_pkg::ST_RP_END:   state_in = smm_pkg::ST_SET_END;
         smm_pkg::ST_SET_END:  state_in = smm_pkg::ST_WALK;
         smm_pkg::ST_WALK: begin
            state_in = status.p_done ? smm_pkg::ST_IDLE : smm_pkg::ST_BCHK;
         end
         smm_pkg::ST_BCHK: begin
            wait_in = 3'd0;
            state_in = status.col_ok ? smm_pkg::ST_CALC : smm_pkg::ST_WALK;
         end
         smm_pkg::ST_CALC: begin
            wait_in = wait_ff + 3'd1;
            if (wait_ff == smm_pkg::FP_WAIT - 3'd1) begin
               state_in = smm_pkg::ST_WRITE;
            end
         end
         smm_pkg::ST_WRITE: state_in = smm_pkg::ST_WALK;
         smm_pkg::ST_ROW_BEGIN: begin
            state_in = status.occ_none ? smm_pkg::ST_EMPTY : smm_pkg::ST_SCAN;
         end
         smm_pkg::ST_SCAN: begin
            if (status.occ_k) begin
               state_in = smm_pkg::ST_EMIT;
            end
         end
         smm_pkg::ST_EMIT: begin
            state_in = status.is_last ? smm_pkg::ST_ROW_DONE : smm_pkg::ST_SCAN;
         end
         smm_pkg::ST_EMPTY:    state_in = smm_pkg::ST_ROW_DONE;
         smm_pkg::ST_ROW_DONE: state_in = smm_pkg::ST_IDLE;
         default:              state_in = smm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         smm_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.cap      = 1'b1;
               cmd.wr_rp    = (status.op == smm_pkg::OP_LOAD_PTR);
               cmd.wr_b     = (status.op == smm_pkg::OP_LOAD_NZ);
               cmd.new_prod = (status.op == smm_pkg::OP_NEW);
            end
         end
         smm_pkg::ST_RP_START: cmd.rd_rp = 1'b1;
         smm_pkg::ST_RP_END: begin
            cmd.rd_rp  = 1'b1;
            cmd.rp_sel = 1'b1;
            cmd.set_p  = 1'b1;
         end
         smm_pkg::ST_SET_END: cmd.set_end = 1'b1;
         smm_pkg::ST_WALK: cmd.rd_b = !status.p_done;
         smm_pkg::ST_BCHK: begin
            cmd.rd_sum = status.col_ok;
            cmd.inc_p  = !status.col_ok;
         end
         smm_pkg::ST_CALC: cmd = '0;
         smm_pkg::ST_WRITE: begin
            cmd.wr_sum = 1'b1;
            cmd.inc_p  = 1'b1;
         end
         smm_pkg::ST_ROW_BEGIN: begin
            cmd.commit_total = 1'b1;
            cmd.scan_rst     = 1'b1;
         end
         smm_pkg::ST_SCAN: begin
            cmd.rd_scan = status.occ_k;
            cmd.inc_k   = !status.occ_k;
         end
         smm_pkg::ST_EMIT:     cmd.emit = 1'b1;
         smm_pkg::ST_EMPTY:    cmd.emit_empty = 1'b1;
         smm_pkg::ST_ROW_DONE: cmd.clear_row = 1'b1;
         default:              cmd = '0;
      endcase
   end

endmodule

// File: design/smm_dp.sv
// Datapath of the sparse matrix multiply block: stores, float multiply-add and output.
`timescale 1ns / 1ps
module smm_dp #(
   parameter int MAX_COLUMNS    = smm_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_B_ROWS     = smm_pkg::MAX_B_ROWS_DEF,
   parameter int MAX_B_NONZEROS = smm_pkg::MAX_B_NONZEROS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smm_pkg::cmd_type              cmd,
   output smm_pkg::status_type           status,
   input  logic [smm_pkg::OP_W-1:0]      req_op,
   input  logic [smm_pkg::ADDR_W-1:0]    req_load_address,
   input  logic [smm_pkg::PTR_W-1:0]     req_row_pointer,
   input  logic [smm_pkg::COL_W-1:0]     req_b_column,
   input  logic [smm_pkg::COL_W-1:0]     req_a_column,
   input  logic [smm_pkg::VAL_W-1:0]     req_value_bits,
   input  logic                          csr_write_enable,
   input  logic [smm_pkg::CSR_W-1:0]     csr_write_data,
   output logic                          rsp_strobe,
   output logic [smm_pkg::ROW_W-1:0]     rsp_row_number,
   output logic [smm_pkg::COL_W-1:0]     rsp_out_column,
   output logic [smm_pkg::VAL_W-1:0]     rsp_out_value,
   output logic                          rsp_has_entry,
   output logic [smm_pkg::TOTAL_W-1:0]   rsp_row_end_count,
   output logic                          rsp_last
);

   localparam int CIW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CNTW = $clog2(MAX_COLUMNS + 1);
   localparam int RAW  = $clog2(MAX_B_ROWS + 1);
   localparam int NAW  = (MAX_B_NONZEROS > 1) ? $clog2(MAX_B_NONZEROS) : 1;

   // Stores and configuration.
   logic [smm_pkg::PTR_W-1:0] rp_mem [MAX_B_ROWS + 1];
   logic [smm_pkg::COL_W-1:0] bcol_mem [MAX_B_NONZEROS];
   logic [smm_pkg::VAL_W-1:0] bval_mem [MAX_B_NONZEROS];
   logic [smm_pkg::VAL_W-1:0] sum_mem [MAX_COLUMNS];

   logic [smm_pkg::CSR_W-1:0] csr_ff;
   logic [smm_pkg::COL_W-1:0] acol_ff;
   logic [smm_pkg::VAL_W-1:0] av_ff;
   logic [smm_pkg::PTR_W-1:0] rp_q_ff;
   logic [smm_pkg::PTR_W-1:0] p_ff;
   logic [smm_pkg::PTR_W-1:0] end_ff;
   logic [smm_pkg::COL_W-1:0] bcol_q_ff;
   logic [smm_pkg::VAL_W-1:0] bval_q_ff;
   logic [smm_pkg::VAL_W-1:0] sum_q_ff;
   logic                      sum_occ_ff;
   logic [MAX_COLUMNS-1:0]    occ_ff;
   logic [CNTW-1:0]           occ_cnt_ff;
   logic [CNTW-1:0]           idx_ff;
   logic [CIW-1:0]            k_ff;
   logic [smm_pkg::ROW_W-1:0] row_ff;
   logic [smm_pkg::TOTAL_W-1:0] total_ff;
   logic [smm_pkg::TOTAL_W:0]   total_in;

   logic [31:0]               la32;
   logic [31:0]               rp_ra32;
   logic [31:0]               p32;
   logic [31:0]               bcol32;
   logic [CIW-1:0]            bidx;
   logic [CIW-1:0]            sum_ra;
   logic [smm_pkg::CSR_W-1:0] eff_cols;
   logic [smm_pkg::VAL_W-1:0] sum_val;
   logic                      is_last;

   assign la32    = 32'(req_load_address);
   assign rp_ra32 = 32'(acol_ff) + 32'(cmd.rp_sel);
   assign p32     = 32'(p_ff);
   assign bcol32  = 32'(bcol_q_ff);
   assign bidx    = bcol32[CIW-1:0];
   assign sum_ra  = cmd.rd_scan ? k_ff : bidx;
   assign sum_val = sum_occ_ff ? sum_q_ff : '0;
   assign is_last = ((CNTW + 1)'(idx_ff) + (CNTW + 1)'(1)) == (CNTW + 1)'(occ_cnt_ff);

   always_comb begin
      if (csr_ff == '0) begin
         eff_cols = smm_pkg::CSR_W'(1);
      end else if (32'(csr_ff) > MAX_COLUMNS) begin
         eff_cols = smm_pkg::CSR_W'(MAX_COLUMNS);
      end else begin
         eff_cols = csr_ff;
      end
   end

   assign status.op       = req_op;
   assign status.row_ok   = (32'(req_a_column) + 32'd1) <= MAX_B_ROWS;
   assign status.p_done   = !(p_ff < end_ff) || (p32 >= MAX_B_NONZEROS);
   assign status.col_ok   = (smm_pkg::CSR_W'(bcol_q_ff) < eff_cols);
   assign status.occ_k    = occ_ff[k_ff];
   assign status.occ_none = (occ_cnt_ff == '0);
   assign status.is_last  = is_last;

   // Memories.
   always_ff @(posedge clock) begin
      if (cmd.wr_rp && la32 <= MAX_B_ROWS) begin
         rp_mem[la32[RAW-1:0]] <= req_row_pointer;
      end
      if (cmd.rd_rp) begin
         rp_q_ff <= rp_mem[rp_ra32[RAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_b && la32 < MAX_B_NONZEROS) begin
         bcol_mem[la32[NAW-1:0]] <= req_b_column;
         bval_mem[la32[NAW-1:0]] <= req_value_bits;
      end
      if (cmd.rd_b) begin
         bcol_q_ff <= bcol_mem[p32[NAW-1:0]];
         bval_q_ff <= bval_mem[p32[NAW-1:0]];
      end
   end

   logic [smm_pkg::VAL_W-1:0] res_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_sum) begin
         sum_mem[bidx] <= res_ff;
      end
      if (cmd.rd_sum || cmd.rd_scan) begin
         sum_q_ff   <= sum_mem[sum_ra];
         sum_occ_ff <= occ_ff[sum_ra];
      end
   end

   // Captured operand and walk registers.
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         acol_ff <= req_a_column;
         av_ff   <= req_value_bits;
      end
      if (cmd.set_p) begin
         p_ff <= rp_q_ff;
      end else if (cmd.inc_p) begin
         p_ff <= p_ff + smm_pkg::PTR_W'(1);
      end
      if (cmd.set_end) begin
         end_ff <= rp_q_ff;
      end
   end

   assign total_in = (smm_pkg::TOTAL_W + 1)'(total_ff) + (smm_pkg::TOTAL_W + 1)'(occ_cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff     <= smm_pkg::COLUMN_COUNT_RESET;
         occ_ff     <= '0;
         occ_cnt_ff <= '0;
         idx_ff     <= '0;
         k_ff       <= '0;
         row_ff     <= '0;
         total_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            csr_ff <= csr_write_data;
         end
         if (cmd.new_prod) begin
            occ_ff     <= '0;
            occ_cnt_ff <= '0;
            row_ff     <= '0;
            total_ff   <= '0;
         end
         if (cmd.wr_sum && !occ_ff[bidx]) begin
            occ_ff[bidx] <= 1'b1;
            occ_cnt_ff   <= occ_cnt_ff + CNTW'(1);
         end
         if (cmd.commit_total) begin
            total_ff <= (total_in > smm_pkg::TOTAL_SAT) ?
                        smm_pkg::TOTAL_SAT[smm_pkg::TOTAL_W-1:0] :
                        total_in[smm_pkg::TOTAL_W-1:0];
         end
         if (cmd.scan_rst) begin
            k_ff   <= '0;
            idx_ff <= '0;
         end else if (cmd.emit) begin
            k_ff   <= k_ff + CIW'(1);
            idx_ff <= idx_ff + CNTW'(1);
         end else if (cmd.inc_k) begin
            k_ff <= k_ff + CIW'(1);
         end
         if (cmd.clear_row) begin
            occ_ff     <= '0;
            occ_cnt_ff <= '0;
            if (row_ff != smm_pkg::ROW_SAT) begin
               row_ff <= row_ff + smm_pkg::ROW_W'(1);
            end
         end
      end
   end

   // Float multiply: decode and mantissa product.
   logic [7:0]  ma_e, mb_e, ma_ee, mb_ee;
   logic [23:0] ma_m, mb_m;
   logic        ma_nan, mb_nan, ma_inf, mb_inf, ma_zero, mb_zero;
   logic        m1_spec_in;
   logic [31:0] m1_sval_in;

   logic [47:0]        m1_prod_ff;
   logic signed [11:0] m1_exp_ff;
   logic               m1_sign_ff, m1_spec_ff;
   logic [31:0]        m1_sval_ff;

   assign ma_e    = av_ff[30:23];
   assign mb_e    = bval_q_ff[30:23];
   assign ma_ee   = (ma_e == 8'd0) ? 8'd1 : ma_e;
   assign mb_ee   = (mb_e == 8'd0) ? 8'd1 : mb_e;
   assign ma_m    = {ma_e != 8'd0, av_ff[22:0]};
   assign mb_m    = {mb_e != 8'd0, bval_q_ff[22:0]};
   assign ma_nan  = (ma_e == 8'hFF) && (av_ff[22:0] != '0);
   assign mb_nan  = (mb_e == 8'hFF) && (bval_q_ff[22:0] != '0);
   assign ma_inf  = (ma_e == 8'hFF) && (av_ff[22:0] == '0);
   assign mb_inf  = (mb_e == 8'hFF) && (bval_q_ff[22:0] == '0);
   assign ma_zero = (av_ff[30:0] == '0);
   assign mb_zero = (bval_q_ff[30:0] == '0);

   always_comb begin
      m1_spec_in = 1'b1;
      m1_sval_in = '0;
      if (ma_nan) begin
         m1_sval_in = av_ff | smm_pkg::FP_QUIET_BIT;
      end else if (mb_nan) begin
         m1_sval_in = bval_q_ff | smm_pkg::FP_QUIET_BIT;
      end else if ((ma_inf && mb_zero) || (mb_inf && ma_zero)) begin
         m1_sval_in = smm_pkg::FP_DEFAULT_NAN;
      end else if (ma_inf || mb_inf) begin
         m1_sval_in = {av_ff[31] ^ bval_q_ff[31], 8'hFF, 23'd0};
      end else begin
         m1_spec_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      m1_prod_ff <= ma_m * mb_m;
      m1_exp_ff  <= $signed({4'd0, ma_ee}) + $signed({4'd0, mb_ee}) - 12'sd126;
      m1_sign_ff <= av_ff[31] ^ bval_q_ff[31];
      m1_spec_ff <= m1_spec_in;
      m1_sval_ff <= m1_sval_in;
   end

   // Float multiply: normalise, then round.
   logic [5:0]         m2_lz;
   logic [47:0]        m2_sig_ff;
   logic signed [11:0] m2_exp_ff;
   logic               m2_sign_ff, m2_spec_ff, m2_zero_ff;
   logic [31:0]        m2_sval_ff;
   logic [31:0]        prod_ff;

   assign m2_lz = smm_pkg::fp_lzc48(m1_prod_ff);

   always_ff @(posedge clock) begin
      m2_sig_ff  <= m1_prod_ff << m2_lz;
      m2_exp_ff  <= m1_exp_ff - $signed({6'd0, m2_lz});
      m2_sign_ff <= m1_sign_ff;
      m2_spec_ff <= m1_spec_ff;
      m2_sval_ff <= m1_sval_ff;
      m2_zero_ff <= (m1_prod_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (m2_spec_ff) begin
         prod_ff <= m2_sval_ff;
      end else if (m2_zero_ff) begin
         prod_ff <= {m2_sign_ff, 31'd0};
      end else begin
         prod_ff <= smm_pkg::fp_round_pack(m2_sign_ff, m2_exp_ff, m2_sig_ff);
      end
   end

   // Float add: decode and align.
   logic [7:0]  aa_e, ab_e, aa_ee, ab_ee, al_e, as_e, ad;
   logic [23:0] aa_m, ab_m;
   logic        aa_nan, ab_nan, aa_inf, ab_inf, a_swap;
   logic [26:0] al_x, as_x;
   logic [4:0]  aamt;
   logic [58:0] ashift;
   logic        a1_spec_in;
   logic [31:0] a1_sval_in;

   logic [26:0] a1_big_ff, a1_small_ff;
   logic        a1_sub_ff, a1_sign_ff, a1_zsign_ff, a1_spec_ff;
   logic [7:0]  a1_exp_ff;
   logic [31:0] a1_sval_ff;

   assign aa_e   = sum_val[30:23];
   assign ab_e   = prod_ff[30:23];
   assign aa_ee  = (aa_e == 8'd0) ? 8'd1 : aa_e;
   assign ab_ee  = (ab_e == 8'd0) ? 8'd1 : ab_e;
   assign aa_m   = {aa_e != 8'd0, sum_val[22:0]};
   assign ab_m   = {ab_e != 8'd0, prod_ff[22:0]};
   assign aa_nan = (aa_e == 8'hFF) && (sum_val[22:0] != '0);
   assign ab_nan = (ab_e == 8'hFF) && (prod_ff[22:0] != '0);
   assign aa_inf = (aa_e == 8'hFF) && (sum_val[22:0] == '0);
   assign ab_inf = (ab_e == 8'hFF) && (prod_ff[22:0] == '0);
   assign a_swap = {ab_ee, ab_m} > {aa_ee, aa_m};
   assign al_e   = a_swap ? ab_ee : aa_ee;
   assign as_e   = a_swap ? aa_ee : ab_ee;
   assign al_x   = {(a_swap ? ab_m : aa_m), 3'd0};
   assign as_x   = {(a_swap ? aa_m : ab_m), 3'd0};
   assign ad     = al_e - as_e;
   assign aamt   = (ad > 8'd31) ? 5'd31 : ad[4:0];
   assign ashift = {as_x, 32'd0} >> aamt;

   always_comb begin
      a1_spec_in = 1'b1;
      a1_sval_in = '0;
      if (aa_nan) begin
         a1_sval_in = sum_val | smm_pkg::FP_QUIET_BIT;
      end else if (ab_nan) begin
         a1_sval_in = prod_ff | smm_pkg::FP_QUIET_BIT;
      end else if (aa_inf && ab_inf && (sum_val[31] != prod_ff[31])) begin
         a1_sval_in = smm_pkg::FP_DEFAULT_NAN;
      end else if (aa_inf) begin
         a1_sval_in = sum_val;
      end else if (ab_inf) begin
         a1_sval_in = prod_ff;
      end else begin
         a1_spec_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      a1_big_ff   <= al_x;
      a1_small_ff <= ashift[58:32] | {26'd0, |ashift[31:0]};
      a1_sub_ff   <= sum_val[31] ^ prod_ff[31];
      a1_sign_ff  <= a_swap ? prod_ff[31] : sum_val[31];
      a1_zsign_ff <= sum_val[31] & prod_ff[31];
      a1_exp_ff   <= al_e;
      a1_spec_ff  <= a1_spec_in;
      a1_sval_ff  <= a1_sval_in;
   end

   // Float add: sum, normalise, round.
   logic [27:0] a2_s_ff;
   logic        a2_sign_ff, a2_zsign_ff, a2_spec_ff;
   logic [7:0]  a2_exp_ff;
   logic [31:0] a2_sval_ff;

   always_ff @(posedge clock) begin
      if (a1_sub_ff) begin
         a2_s_ff <= 28'(a1_big_ff) - 28'(a1_small_ff);
      end else begin
         a2_s_ff <= 28'(a1_big_ff) + 28'(a1_small_ff);
      end
      a2_sign_ff  <= a1_sign_ff;
      a2_zsign_ff <= a1_zsign_ff;
      a2_exp_ff   <= a1_exp_ff;
      a2_spec_ff  <= a1_spec_ff;
      a2_sval_ff  <= a1_sval_ff;
   end

   logic [47:0]        a3_wide;
   logic [5:0]         a3_lz;
   logic [47:0]        a3_sig_ff;
   logic signed [11:0] a3_exp_ff;
   logic               a3_sign_ff, a3_zsign_ff, a3_spec_ff, a3_zero_ff;
   logic [31:0]        a3_sval_ff;

   assign a3_wide = {a2_s_ff, 20'd0};
   assign a3_lz   = smm_pkg::fp_lzc48(a3_wide);

   always_ff @(posedge clock) begin
      a3_sig_ff   <= a3_wide << a3_lz;
      a3_exp_ff   <= $signed({4'd0, a2_exp_ff}) + 12'sd1 - $signed({6'd0, a3_lz});
      a3_sign_ff  <= a2_sign_ff;
      a3_zsign_ff <= a2_zsign_ff;
      a3_zero_ff  <= (a2_s_ff == '0);
      a3_spec_ff  <= a2_spec_ff;
      a3_sval_ff  <= a2_sval_ff;
   end

   always_ff @(posedge clock) begin
      if (a3_spec_ff) begin
         res_ff <= a3_sval_ff;
      end else if (a3_zero_ff) begin
         res_ff <= {a3_zsign_ff, 31'd0};
      end else begin
         res_ff <= smm_pkg::fp_round_pack(a3_sign_ff, a3_exp_ff, a3_sig_ff);
      end
   end

   // Result register.
   logic rsp_strobe_ff;
   logic [smm_pkg::ROW_W-1:0]   rsp_row_ff;
   logic [smm_pkg::COL_W-1:0]   rsp_col_ff;
   logic [smm_pkg::VAL_W-1:0]   rsp_val_ff;
   logic                        rsp_has_ff;
   logic [smm_pkg::TOTAL_W-1:0] rsp_cnt_ff;
   logic                        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit || cmd.emit_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit || cmd.emit_empty) begin
         rsp_row_ff  <= row_ff;
         rsp_cnt_ff  <= total_ff;
         rsp_has_ff  <= cmd.emit;
         rsp_col_ff  <= cmd.emit ? smm_pkg::COL_W'(k_ff) : '0;
         rsp_val_ff  <= cmd.emit ? sum_val : '0;
         rsp_last_ff <= cmd.emit ? is_last : 1'b1;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_row_number    = rsp_row_ff;
   assign rsp_out_column    = rsp_col_ff;
   assign rsp_out_value     = rsp_val_ff;
   assign rsp_has_entry     = rsp_has_ff;
   assign rsp_row_end_count = rsp_cnt_ff;
   assign rsp_last          = rsp_last_ff;

   // The occupancy count must always match the marks it summarises.
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      32'(occ_cnt_ff) == $countones(occ_ff))
      else $error("occupancy count out of step with column marks");

   // An empty-row marker is always the final transaction of its row.
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_has_entry |-> rsp_last && rsp_out_value == '0)
      else $error("empty-row marker without last or with a value");

   // The row finish step always separates two rows' transactions.
   a_row_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("transaction straight after the end of a row");

   // Every emitted column had been marked occupied when it was read.
   a_emit_marked: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sum_occ_ff && occ_ff[k_ff])
      else $error("emitting a column that is not occupied");

endmodule

// File: design/sparse_matrix_multiply_csr.sv
// Loads and new-product transactions are taken without leaving the idle state.
// An A nonzero walks its B row one entry at a time: each entry inside the column
// count passes through the seven-stage float multiply-add in turn; others are skipped.
// An end of row scans the columns and emits each occupied one or an empty-row marker.
// Results appear one per strobe and the receiver cannot stall.
// Reset is synchronous and clears control, marks and counts; B stores are not reset.
`timescale 1ns / 1ps
module sparse_matrix_multiply_csr #(
   parameter int MAX_COLUMNS    = smm_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_B_ROWS     = smm_pkg::MAX_B_ROWS_DEF,
   parameter int MAX_B_NONZEROS = smm_pkg::MAX_B_NONZEROS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [smm_pkg::OP_W-1:0]    req_op,
   input  logic [smm_pkg::ADDR_W-1:0]  req_load_address,
   input  logic [smm_pkg::PTR_W-1:0]   req_row_pointer,
   input  logic [smm_pkg::COL_W-1:0]   req_b_column,
   input  logic [smm_pkg::COL_W-1:0]   req_a_column,
   input  logic [smm_pkg::VAL_W-1:0]   req_value_bits,
   input  logic                        csr_write_enable,
   input  logic [smm_pkg::CSR_W-1:0]   csr_write_data,
   output logic                        rsp_strobe,
   output logic [smm_pkg::ROW_W-1:0]   rsp_row_number,
   output logic [smm_pkg::COL_W-1:0]   rsp_out_column,
   output logic [smm_pkg::VAL_W-1:0]   rsp_out_value,
   output logic                        rsp_has_entry,
   output logic [smm_pkg::TOTAL_W-1:0] rsp_row_end_count,
   output logic                        rsp_last
);

   smm_pkg::cmd_type    cmd;
   smm_pkg::status_type status;

   smm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   smm_dp #(
      .MAX_COLUMNS    (MAX_COLUMNS),
      .MAX_B_ROWS     (MAX_B_ROWS),
      .MAX_B_NONZEROS (MAX_B_NONZEROS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_op),
      .req_load_address  (req_load_address),
      .req_row_pointer   (req_row_pointer),
      .req_b_column      (req_b_column),
      .req_a_column      (req_a_column),
      .req_value_bits    (req_value_bits),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_row_number    (rsp_row_number),
      .rsp_out_column    (rsp_out_column),
      .rsp_out_value     (rsp_out_value),
      .rsp_has_entry     (rsp_has_entry),
      .rsp_row_end_count (rsp_row_end_count),
      .rsp_last          (rsp_last)
   );

endmodule
